// ===== hw/rtl/lsbse_pkg.sv =====
// Shared types and codes for the two-bit LSB stego embed/extract block.
package lsbse_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [1:0] KIND_STEGO  = 2'd0;
    localparam logic [1:0] KIND_DIMS   = 2'd1;
    localparam logic [1:0] KIND_SECRET = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [7:0] LOW_CLEAR = 8'b11111100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // One classified pixel as it sits in the queue.
    typedef struct packed {
        logic       fs;      // frame start seen on this word
        logic       hdr;     // one of the four header pixels
        logic [1:0] slot;    // header pixel index
        logic [1:0] phase;   // pixel index within a payload group
        t_pix       cover_pix;
        t_pix       hidden;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        t_pix        pix;
        logic [11:0] found_width;
        logic [11:0] found_height;
    } t_result;

endpackage

// ===== hw/rtl/lsbse_front.sv =====
// Front end: tracks frame position and group phase, classifies each pixel.
module lsbse_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_frame_start,
    input  lsbse_pkg::t_pix      i_cover,
    input  lsbse_pkg::t_pix      i_hidden,
    output lsbse_pkg::t_item     o_item
);

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] n_pos;
    logic [1:0]               r_phase;
    logic [1:0]               n_phase;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [1:0]               cur_phase;
    logic                     hdr;

    always_comb begin
        cur_pos   = i_frame_start ? '0 : r_pos;
        hdr       = (cur_pos[POSITION_BITS-1:2] == '0);
        cur_phase = (i_frame_start || hdr) ? 2'd0 : r_phase;
        // position saturates so the header is never re-entered without frame start
        n_pos     = (&cur_pos) ? cur_pos : cur_pos + POSITION_BITS'(1);
        n_phase   = hdr ? 2'd0 : cur_phase + 2'd1;

        o_item.fs        = i_frame_start;
        o_item.hdr       = hdr;
        o_item.slot      = cur_pos[1:0];
        o_item.phase     = cur_phase;
        o_item.cover_pix = i_cover;
        o_item.hidden    = i_hidden;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= 2'd0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_frame_start) |=> (r_pos >= $past(r_pos)))
        else $error("frame position moved back without frame start");

endmodule

// ===== hw/rtl/lsbse_queue.sv =====
// Small FIFO between the classifying front end and the executing back end.
module lsbse_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lsbse_pkg::t_item  i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output lsbse_pkg::t_item  o_item
);

    lsbse_pkg::t_item                 r_mem [lsbse_pkg::QUEUE_DEPTH];
    logic [lsbse_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [lsbse_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [lsbse_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (lsbse_pkg::QUEUE_AW+1)'(lsbse_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (lsbse_pkg::QUEUE_AW+1)'(lsbse_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// ===== hw/rtl/lsbse_back.sv =====
// Back end: embeds or extracts bits for each queued pixel, drives the output register.
module lsbse_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mode,
    input  logic [11:0]        i_secret_width,
    input  logic [11:0]        i_secret_height,
    input  logic [23:0]        i_embed_area,
    input  logic               i_valid,
    input  lsbse_pkg::t_item   i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    output lsbse_pkg::t_result o_result,
    input  logic               i_out_ready
);

    logic                r_out_valid;
    lsbse_pkg::t_result  r_result;
    logic [23:0]         r_cnt;
    logic [23:0]         n_cnt;
    logic [23:0]         r_held;
    logic [23:0]         n_held;
    logic [23:0]         r_collect;
    logic [23:0]         n_collect;
    logic [11:0]         r_dw;
    logic [11:0]         n_dw;
    logic [11:0]         r_dh;
    logic [11:0]         n_dh;
    logic [23:0]         r_dec_area;
    logic [23:0]         n_dec_area;
    logic [23:0]         base_cnt;
    logic [23:0]         base_collect;
    logic [23:0]         held_now;
    logic [11:0]         hv;
    logic [5:0]          six;
    logic [5:0]          bits6;
    logic                produce;
    lsbse_pkg::t_result  res;

    assign o_pop       = i_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        base_cnt     = i_item.fs ? 24'd0 : r_cnt;
        base_collect = i_item.fs ? 24'd0 : r_collect;
        six          = {i_item.cover_pix.red[1:0], i_item.cover_pix.green[1:0],
                        i_item.cover_pix.blue[1:0]};
        held_now     = (i_item.phase == 2'd0) ? i_item.hidden : r_held;
        n_cnt        = base_cnt;
        n_collect    = base_collect;
        n_held       = r_held;
        n_dw         = r_dw;
        n_dh         = r_dh;
        n_dec_area   = r_dec_area;
        hv           = i_item.slot[1] ? i_secret_height : i_secret_width;
        bits6        = 6'd0;
        produce      = 1'b0;
        res          = '0;

        if (i_mode == lsbse_pkg::MODE_EMBED) begin
            produce  = 1'b1;
            res.kind = lsbse_pkg::KIND_STEGO;
            if (i_item.hdr) begin
                bits6 = i_item.slot[0] ? hv[5:0] : hv[11:6];
            end else begin
                n_held = held_now;
                if (base_cnt < i_embed_area) begin
                    case (i_item.phase)
                        2'd0:    bits6 = held_now[23:18];
                        2'd1:    bits6 = held_now[17:12];
                        2'd2:    bits6 = held_now[11:6];
                        default: bits6 = held_now[5:0];
                    endcase
                    if (i_item.phase == 2'd3) begin
                        n_cnt = base_cnt + 24'd1;
                    end
                end
            end
            res.pix.red   = (i_item.cover_pix.red   & lsbse_pkg::LOW_CLEAR)
                            | {6'd0, bits6[5:4]};
            res.pix.green = (i_item.cover_pix.green & lsbse_pkg::LOW_CLEAR)
                            | {6'd0, bits6[3:2]};
            res.pix.blue  = (i_item.cover_pix.blue  & lsbse_pkg::LOW_CLEAR)
                            | {6'd0, bits6[1:0]};
        end else begin
            if (i_item.hdr) begin
                case (i_item.slot)
                    2'd0:    n_dw = {6'd0, six};
                    2'd1:    n_dw = {r_dw[5:0], six};
                    2'd2:    n_dh = {6'd0, six};
                    default: n_dh = {r_dh[5:0], six};
                endcase
                // keep the decoded area registered for the payload compare
                n_dec_area = 24'(n_dw) * 24'(n_dh);
                if (i_item.slot == 2'd3) begin
                    produce          = 1'b1;
                    res.kind         = lsbse_pkg::KIND_DIMS;
                    res.found_width  = n_dw;
                    res.found_height = n_dh;
                end
            end else begin
                n_collect = (i_item.phase == 2'd0) ? {18'd0, six}
                                                   : {base_collect[17:0], six};
                if ((i_item.phase == 2'd3) && (base_cnt < r_dec_area)) begin
                    produce       = 1'b1;
                    res.kind      = lsbse_pkg::KIND_SECRET;
                    res.pix       = n_collect;
                    n_cnt         = base_cnt + 24'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_held      <= '0;
            r_collect   <= '0;
            r_dw        <= '0;
            r_dh        <= '0;
            r_dec_area  <= '0;
        end else begin
            if (o_pop) begin
                r_cnt      <= n_cnt;
                r_held     <= n_held;
                r_collect  <= n_collect;
                r_dw       <= n_dw;
                r_dh       <= n_dh;
                r_dec_area <= n_dec_area;
            end
            if (o_pop && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            r_result <= res;
        end
    end

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.kind != lsbse_pkg::KIND_DIMS)
            |-> (r_result.found_width == '0 && r_result.found_height == '0))
        else $error("dimension fields set on a pixel word");

    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.kind == lsbse_pkg::KIND_DIMS) |-> (r_result.pix == '0))
        else $error("pixel fields set on a dimension word");

endmodule

// ===== hw/rtl/lsb_image_stego_embed_extract_top.sv =====
// Top level of the two-bit LSB stego embed/extract block.
//
// Pixels enter on the s_axis channel (tuser = frame start, tdata = cover and
// secret pixel) and results leave on m_axis (tuser = kind). In embed mode every
// pixel gives one stego word; in extract mode the dimensions come out after the
// fourth header pixel and each secret pixel after the last pixel of its group.
// Registers (mode, secret width, secret height) are written on the cfg channel,
// which is always ready. The user must write them only while the stream is idle;
// the block itself does not enforce this. Throughput: one pixel per clock while
// m_axis_tready stays high. After a pixel is accepted, its result passes
// through a queue entry and then the back end's output register.
// A four-word queue sits between pixel classification and bit processing; when
// m_axis_tready is held low the output register holds its word, the queue
// fills and s_axis_tready drops once four pixels are waiting.
// Reset clears the registers, frame position, counters and decoded dimensions;
// the stream then behaves as if a frame had just begun.
module lsb_image_stego_embed_extract_top #(
    parameter int POSITION_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cover_red, cover_green, cover_blue, hidden_red, hidden_green, hidden_blue
    input  logic [47:0] s_axis_tdata,
    // frame_start
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red, out_green, out_blue, found_width, found_height
    output logic [47:0] m_axis_tdata,
    // kind
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic                r_mode;
    logic [11:0]         r_sw;
    logic [11:0]         r_sh;
    logic [23:0]         r_embed_area;
    logic                cfg_wr;
    logic                in_accept;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    lsbse_pkg::t_pix     cover_pix;
    lsbse_pkg::t_pix     hidden;
    lsbse_pkg::t_item    f_item;
    lsbse_pkg::t_item    q_item;
    lsbse_pkg::t_result  result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // area follows the write so it is ready for the very next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= lsbse_pkg::MODE_EMBED;
            r_sw         <= '0;
            r_sh         <= '0;
            r_embed_area <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                lsbse_pkg::CFG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                lsbse_pkg::CFG_WIDTH: begin
                    r_sw         <= i_cfg_data;
                    r_embed_area <= 24'(i_cfg_data) * 24'(r_sh);
                end
                lsbse_pkg::CFG_HEIGHT: begin
                    r_sh         <= i_cfg_data;
                    r_embed_area <= 24'(r_sw) * 24'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign cover_pix.red   = s_axis_tdata[7:0];
    assign cover_pix.green = s_axis_tdata[15:8];
    assign cover_pix.blue  = s_axis_tdata[23:16];
    assign hidden.red      = s_axis_tdata[31:24];
    assign hidden.green    = s_axis_tdata[39:32];
    assign hidden.blue     = s_axis_tdata[47:40];

    lsbse_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (s_axis_tuser[0]),
        .i_cover       (cover_pix),
        .i_hidden      (hidden),
        .o_item        (f_item)
    );

    lsbse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    lsbse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (r_mode),
        .i_secret_width  (r_sw),
        .i_secret_height (r_sh),
        .i_embed_area    (r_embed_area),
        .i_valid         (q_valid),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .o_out_valid     (m_axis_tvalid),
        .o_result        (result),
        .i_out_ready     (m_axis_tready)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {result.found_height, result.found_width,
                           result.pix.blue, result.pix.green, result.pix.red};

endmodule
